[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files of the queue manager
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, masked while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("queue manager check failed");

// condition that must never be seen at a rising edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

[hw/rtl/llq_pkg.sv]
// shared types and constants of the linked list queue manager
// no dependencies
`default_nettype none

package llq_pkg;

	localparam int IDX_W     = 6;
	localparam int CNT_W     = 7;
	localparam int NODES_DEF = 64;

	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_LINKED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [IDX_W-1:0] node_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic             is_member;
		logic [CNT_W-1:0] element_count;
		logic [IDX_W-1:0] head_index;
		logic             head_valid;
	} rsp_t;

endpackage

`default_nettype wire

[hw/rtl/llq_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module llq_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/llq_ctrl.sv]
// request sequencer: pointer tables, linked flags, head and count
// depends on llq_pkg, llq_ram and assert_macros.svh
`default_nettype none

module llq_ctrl #(
	parameter int NODES = llq_pkg::NODES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire llq_pkg::req_t req,
	output logic               idle,
	output logic               res_valid,
	input  wire logic          res_ready,
	output llq_pkg::rsp_t      res
);

	import llq_pkg::*;
	`include "assert_macros.svh"

	// only indices reachable through the 6-bit field are ever stored
	localparam int DEPTH = (NODES < (1 << IDX_W)) ? NODES : (1 << IDX_W);
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [12:0] NODES_L = 13'(NODES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_FIN
	} state_t;

	state_t           state_q;
	logic [1:0]       req_q;
	logic [IDX_W-1:0] node_q;
	status_t          status_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [DEPTH-1:0] linked_q;

	logic             nx_we, pv_we, rd_en;
	logic [PTR_W-1:0] nx_waddr, nx_wdata, nx_raddr, nx_rdata;
	logic [PTR_W-1:0] pv_waddr, pv_wdata, pv_raddr, pv_rdata;

	logic [PTR_W-1:0] node_a;
	logic             in_range, flag, empty;
	logic             append_ok, remove_ok;
	status_t          status_d;
	logic [CNT_W-1:0] count_step, count_nx;

	llq_ram #(.WIDTH(PTR_W), .DEPTH(DEPTH)) u_next (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.re    (rd_en),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	llq_ram #(.WIDTH(PTR_W), .DEPTH(DEPTH)) u_prev (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.re    (rd_en),
		.raddr (pv_raddr),
		.rdata (pv_rdata)
	);

	assign node_a   = node_q[PTR_W-1:0];
	assign in_range = {7'd0, node_q} < NODES_L;
	assign flag     = in_range && linked_q[node_a];
	assign empty    = (count_q == '0);

	assign append_ok = (req_q == REQ_APPEND) && in_range && !flag;
	assign remove_ok = (req_q == REQ_REMOVE) && !empty && flag;

	// one adder serves both append and remove
	assign count_step = (req_q == REQ_REMOVE) ? {CNT_W{1'b1}} : CNT_W'(1);
	assign count_nx   = count_q + count_step;

	always_comb begin
		status_d = ST_OK;
		case (req_q)
			REQ_APPEND: begin
				if (!in_range) begin
					status_d = ST_ABSENT;
				end else if (flag) begin
					status_d = ST_LINKED;
				end
			end
			REQ_REMOVE: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (!flag) begin
					status_d = ST_ABSENT;
				end
			end
			default: status_d = ST_OK;
		endcase
	end

	// table ports: reads issued on accept, data used in exec and link
	always_comb begin
		rd_en    = (state_q == S_IDLE) && start;
		nx_raddr = req.node_index[PTR_W-1:0];
		pv_raddr = (req.req_type == REQ_REMOVE) ? req.node_index[PTR_W-1:0] : head_q;
		nx_we    = 1'b0;
		pv_we    = 1'b0;
		nx_waddr = node_a;
		nx_wdata = node_a;
		pv_waddr = node_a;
		pv_wdata = node_a;
		unique case (state_q)
			S_EXEC: begin
				if (append_ok && empty) begin
					nx_we = 1'b1;
					pv_we = 1'b1;
				end else if (append_ok) begin
					// pv_rdata is the tail here
					nx_we    = 1'b1;
					nx_waddr = pv_rdata;
					pv_we    = 1'b1;
					pv_waddr = head_q;
				end else if (remove_ok) begin
					nx_we    = 1'b1;
					nx_waddr = pv_rdata;
					nx_wdata = nx_rdata;
					pv_we    = 1'b1;
					pv_waddr = nx_rdata;
					pv_wdata = pv_rdata;
				end
			end
			S_LINK: begin
				nx_we    = 1'b1;
				nx_wdata = head_q;
				pv_we    = 1'b1;
				pv_wdata = pv_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			req_q    <= REQ_QUERY;
			node_q   <= '0;
			status_q <= ST_OK;
			head_q   <= '0;
			count_q  <= '0;
			linked_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q   <= req.req_type;
						node_q  <= req.node_index;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= status_d;
					state_q  <= S_FIN;
					if (append_ok) begin
						linked_q[node_a] <= 1'b1;
						count_q          <= count_nx;
						if (empty) begin
							head_q <= node_a;
						end else begin
							state_q <= S_LINK;
						end
					end else if (remove_ok) begin
						linked_q[node_a] <= 1'b0;
						count_q          <= count_nx;
						if (head_q == node_a) begin
							head_q <= nx_rdata;
						end
					end
				end
				S_LINK: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);

	always_comb begin
		res.status        = status_q;
		res.is_member     = flag;
		res.element_count = count_q;
		res.head_index    = empty ? '0 : IDX_W'(head_q);
		res.head_valid    = !empty;
	end

	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`ASSERT_CLK(a_head_linked, clk, arst_n, !empty |-> linked_q[head_q])
	`ASSERT_CLK(a_count_hold, clk, arst_n, state_q != S_EXEC |=> $stable(count_q))

endmodule

`default_nettype wire

[hw/rtl/linked_list_queue_manager_core.sv]
// top level of the circular doubly linked queue manager
// depends on llq_pkg, llq_ctrl and assert_macros.svh
//
//   channel  signals                      item
//   req      req_valid req_ready req      req_type, node_index
//   rsp      rsp_valid rsp_ready rsp      status, is_member, count, head
//
// append to a non-empty queue takes an extra step; the steps of every request are
// accept, table update, (second pointer write), result hand-off
// the extra step is set by the single write port of each pointer table
// arst_n clears state, head, count and every linked flag; tables stay unknown
// a result waits in the output register while the next item is taken in
// the sequencer only halts at hand-off while that register is full and rsp_ready is low
`default_nettype none

module linked_list_queue_manager_core #(
	parameter int NODES = llq_pkg::NODES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire llq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output llq_pkg::rsp_t      rsp
);

	import llq_pkg::*;
	`include "assert_macros.svh"

	logic  start;
	logic  ctrl_idle;
	logic  res_valid;
	logic  res_ready;
	rsp_t  res;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	// new items only while the sequencer is idle
	assign req_ready = ctrl_idle;
	assign start     = req_valid && req_ready;

	llq_ctrl #(.NODES(NODES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (ctrl_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register parts the result side from the sequencer
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload register, no reset
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// an accepted item keeps the sequencer busy the following cycle
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, start |=> !req_ready)

endmodule

`default_nettype wire
